// ===== rtl/bal_pkg.sv =====
// Shared constants, codes and widths for the bounded array list table.
package bal_pkg;

    localparam int CAPACITY = 16;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int LIVE_W   = 5;

    // entry address and live count widths follow from the capacity
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // common width for comparing a request position against the count
    localparam int WW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [KIND_W-1:0] {
        K_SEARCH  = 2'd0,
        K_MODIFY  = 2'd1,
        K_APPEND  = 2'd2,
        K_REPLACE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// ===== rtl/bal_if.sv =====
// Request and response channel interfaces of the bounded array list table.
interface bal_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bal_pkg::KIND_W-1:0]    req_type;
    logic        [bal_pkg::POS_W-1:0]     position;
    logic signed [bal_pkg::DATA_W-1:0]    value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface bal_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bal_pkg::STATUS_W-1:0]  status;
    logic        [bal_pkg::FOUND_W-1:0]   found_index;
    logic signed [bal_pkg::DATA_W-1:0]    old_value;
    logic signed [bal_pkg::DATA_W-1:0]    new_value;
    logic        [bal_pkg::LIVE_W-1:0]    live_count;

    modport source (output valid, output status, output found_index, output old_value,
                    output new_value, output live_count, input ready);
    modport sink   (input valid, input status, input found_index, input old_value,
                    input new_value, input live_count, output ready);
endinterface

// ===== rtl/bounded_array_list_table.sv =====
// Bounded array list table: packed signed list with search, modify, append, replace, remove.
//
// One request is taken at a time; ready is high only while the sequencer is idle, and a
// finished response sits in an output register so the next request can be taken while it
// waits. Entries live in a dual-port memory (one read with registered data and one write
// per cycle) and a single 32-bit equality comparator is reused for every search step.
// Search walks the live entries one per cycle; remove moves one entry per cycle to close
// the gap; modify reads the entry and then writes it, append and replace write it directly.
// Bad index and full requests go straight to the done state. Ready returns in the cycle
// the response goes valid, unless the previous response is still held in the output
// register, which stalls the sequencer until it is taken.
module bounded_array_list_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bal_req_if.sink   i_req,
    bal_rsp_if.source o_rsp
);

    localparam int AW = bal_pkg::AW;
    localparam int CW = bal_pkg::CW;
    localparam int WW = bal_pkg::WW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MOD_RD,
        S_MOD_WR,
        S_APPEND,
        S_REPLACE,
        S_REMOVE,
        S_DONE
    } t_state;

    t_state                             r_state;
    logic        [bal_pkg::POS_W-1:0]   r_pos;
    logic signed [bal_pkg::DATA_W-1:0]  r_val;
    logic        [CW-1:0]               r_count;
    logic        [CW-1:0]               r_ridx;
    logic        [AW-1:0]               r_cidx;
    logic                               r_rv;
    logic signed [bal_pkg::DATA_W-1:0]  r_rdata;

    bal_pkg::t_status                   r_status;
    logic        [bal_pkg::FOUND_W-1:0] r_found;
    logic signed [bal_pkg::DATA_W-1:0]  r_old;
    logic signed [bal_pkg::DATA_W-1:0]  r_new;

    logic                               r_out_vld;
    bal_pkg::t_status                   r_out_status;
    logic        [bal_pkg::FOUND_W-1:0] r_out_found;
    logic signed [bal_pkg::DATA_W-1:0]  r_out_old;
    logic signed [bal_pkg::DATA_W-1:0]  r_out_new;
    logic        [bal_pkg::LIVE_W-1:0]  r_out_live;

    logic signed [bal_pkg::DATA_W-1:0]  r_mem [bal_pkg::CAPACITY];

    logic                               issue;
    logic                               hit;
    logic                               pos_ok;
    logic        [AW-1:0]               rd_addr;
    logic                               w_en;
    logic        [AW-1:0]               w_addr;
    logic signed [bal_pkg::DATA_W-1:0]  w_data;

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_index = r_out_found;
    assign o_rsp.old_value   = r_out_old;
    assign o_rsp.new_value   = r_out_new;
    assign o_rsp.live_count  = r_out_live;

    assign pos_ok = (WW'(i_req.position) < WW'(r_count));
    // the walk pointer runs one entry ahead of the registered read data
    assign issue  = ((r_state == S_SEARCH) || (r_state == S_REMOVE)) && (r_ridx < r_count);
    assign hit    = r_rv && (r_rdata == r_val);

    always_comb begin
        rd_addr = r_ridx[AW-1:0];
        w_en    = 1'b0;
        w_addr  = AW'(r_pos);
        w_data  = r_val;
        unique case (r_state)
            S_MOD_RD:  rd_addr = AW'(r_pos);
            S_MOD_WR:  w_en = 1'b1;
            S_REPLACE: w_en = 1'b1;
            S_APPEND: begin
                w_en   = 1'b1;
                w_addr = AW'(r_count);
            end
            S_REMOVE: begin
                // entry read last cycle drops down one place
                w_en   = r_rv;
                w_addr = AW'(r_cidx - AW'(1));
                w_data = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (r_out_vld && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            r_rv   <= issue;
            r_cidx <= r_ridx[AW-1:0];
            if (issue) begin
                r_ridx <= r_ridx + CW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_pos    <= i_req.position;
                        r_val    <= i_req.value;
                        r_status <= bal_pkg::ST_OK;
                        r_found  <= '0;
                        r_old    <= '0;
                        r_new    <= '0;
                        unique case (bal_pkg::t_kind'(i_req.req_type))
                            bal_pkg::K_SEARCH: begin
                                r_ridx  <= '0;
                                r_state <= S_SEARCH;
                            end
                            bal_pkg::K_MODIFY: begin
                                if (pos_ok) begin
                                    r_state <= S_MOD_RD;
                                end else begin
                                    r_status <= bal_pkg::ST_BAD_INDEX;
                                    r_state  <= S_DONE;
                                end
                            end
                            bal_pkg::K_APPEND: begin
                                if (r_count < CW'(bal_pkg::CAPACITY)) begin
                                    r_state <= S_APPEND;
                                end else begin
                                    r_status <= bal_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end
                            end
                            bal_pkg::K_REPLACE: begin
                                if (!pos_ok) begin
                                    r_status <= bal_pkg::ST_BAD_INDEX;
                                    r_state  <= S_DONE;
                                end else if (i_req.value == '0) begin
                                    r_ridx  <= CW'(i_req.position) + CW'(1);
                                    r_state <= S_REMOVE;
                                end else begin
                                    r_state <= S_REPLACE;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_found <= bal_pkg::FOUND_W'(r_cidx);
                        r_state <= S_DONE;
                    end else if (!issue && !r_rv) begin
                        r_status <= bal_pkg::ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end
                end
                S_MOD_RD: r_state <= S_MOD_WR;
                S_MOD_WR: begin
                    r_old   <= r_rdata;
                    r_new   <= r_val;
                    r_state <= S_DONE;
                end
                S_APPEND: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_REPLACE: r_state <= S_DONE;
                S_REMOVE: begin
                    if (!issue && !r_rv) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_status;
                        r_out_found  <= r_found;
                        r_out_old    <= r_old;
                        r_out_new    <= r_new;
                        r_out_live   <= bal_pkg::LIVE_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(bal_pkg::CAPACITY))
        else $error("live count above capacity");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while sequencer busy");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == bal_pkg::ST_FULL))
            |-> (o_rsp.live_count == bal_pkg::LIVE_W'(bal_pkg::CAPACITY)))
        else $error("full reported below capacity");

    a_err_no_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != bal_pkg::ST_OK))
            |-> ((o_rsp.old_value == '0) && (o_rsp.new_value == '0)))
        else $error("values reported on failed request");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> ((r_count == $past(r_count))
            || (r_count == ($past(r_count) + CW'(1)))
            || (($past(r_count)) == (r_count + CW'(1)))))
        else $error("live count moved by more than one");
`endif

endmodule

// ===== tb/bounded_array_list_table_tb.sv =====
// Self-checking testbench for the bounded array list table: shadow list, random traffic.
module bounded_array_list_table_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        bal_pkg::t_status                   status;
        logic [bal_pkg::FOUND_W-1:0]        found_index;
        logic signed [bal_pkg::DATA_W-1:0]  old_value;
        logic signed [bal_pkg::DATA_W-1:0]  new_value;
        logic [bal_pkg::LIVE_W-1:0]         live_count;
    } t_rsp_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;
    bit   no_idle = 1'b0;

    bal_req_if req_ch();
    bal_rsp_if rsp_ch();

    assign rsp_ch.ready = sink_ready;

    bounded_array_list_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the list
    logic signed [bal_pkg::DATA_W-1:0] shadow_entries [bal_pkg::CAPACITY];
    int unsigned                       shadow_count = 0;

    t_rsp_beat   pending_rsp [$];
    t_rsp_beat   want;
    int unsigned mismatches   = 0;
    int unsigned beats_seen   = 0;
    int unsigned quiet_cycles = 0;

    function automatic t_rsp_beat apply_request(input bal_pkg::t_kind kind,
                                                input logic [bal_pkg::POS_W-1:0] pos,
                                                input logic signed [bal_pkg::DATA_W-1:0] val);
        t_rsp_beat r;
        bit        hit;
        int        i;
        r.status      = bal_pkg::ST_OK;
        r.found_index = '0;
        r.old_value   = '0;
        r.new_value   = '0;
        hit = 1'b0;
        case (kind)
            bal_pkg::K_SEARCH: begin
                for (i = 0; i < int'(shadow_count); i++) begin
                    if (!hit && shadow_entries[i] == val) begin
                        hit = 1'b1;
                        r.found_index = bal_pkg::FOUND_W'(i);
                    end
                end
                if (!hit) r.status = bal_pkg::ST_NOT_FOUND;
            end
            bal_pkg::K_MODIFY: begin
                if (pos < shadow_count) begin
                    r.old_value = shadow_entries[pos];
                    r.new_value = val;
                    shadow_entries[pos] = val;
                end else begin
                    r.status = bal_pkg::ST_BAD_INDEX;
                end
            end
            bal_pkg::K_APPEND: begin
                if (shadow_count < bal_pkg::CAPACITY) begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                end else begin
                    r.status = bal_pkg::ST_FULL;
                end
            end
            default: begin
                if (pos < shadow_count) begin
                    if (val == 0) begin
                        // close the gap: later entries move down one slot
                        for (i = int'(pos); i + 1 < int'(shadow_count); i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        shadow_count--;
                    end else begin
                        shadow_entries[pos] = val;
                    end
                end else begin
                    r.status = bal_pkg::ST_BAD_INDEX;
                end
            end
        endcase
        r.live_count = bal_pkg::LIVE_W'(shadow_count);
        return r;
    endfunction

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(0, 99) < 38);
    endfunction

    // mix of live values, zero, extremes and a small pool for duplicates
    function automatic logic signed [bal_pkg::DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && shadow_count > 0)
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        if (roll < 45)
            return '0;
        if (roll < 55) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (roll < 70)
            return $signed(bal_pkg::DATA_W'($urandom_range(0, 15))) - 32'sd8;
        return $urandom;
    endfunction

    function automatic logic [bal_pkg::POS_W-1:0] pick_position();
        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            return bal_pkg::POS_W'($urandom_range(0, shadow_count - 1));
        return bal_pkg::POS_W'($urandom_range(0, 15));
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [bal_pkg::DATA_W-1:0] got,
                                   input logic [bal_pkg::DATA_W-1:0] wanted);
        mismatches++;
        $display("mismatch beat %0d %s: got %h wanted %h", beats_seen, what, got, wanted);
    endtask

    // valid stays high across back-to-back beats; lowered only in a gap
    task automatic send_request(input bal_pkg::t_kind kind,
                                input logic [bal_pkg::POS_W-1:0] pos,
                                input logic signed [bal_pkg::DATA_W-1:0] val);
        while (take_gap()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_rsp.push_back(apply_request(kind, pos, val));
    endtask

    task automatic test_directed_basics();
        send_request(bal_pkg::K_SEARCH,  4'd0,  32'sd5);
        send_request(bal_pkg::K_MODIFY,  4'd0,  32'sd9);
        send_request(bal_pkg::K_REPLACE, 4'd0,  32'sd7);
        send_request(bal_pkg::K_REPLACE, 4'd0,  32'sd0);
        send_request(bal_pkg::K_APPEND,  4'd15, 32'sh8000_0000);
        send_request(bal_pkg::K_APPEND,  4'd0,  32'sh7FFF_FFFF);
        send_request(bal_pkg::K_APPEND,  4'd0,  32'sd0);
        send_request(bal_pkg::K_APPEND,  4'd0,  -32'sd1);
        send_request(bal_pkg::K_APPEND,  4'd0,  32'sh7FFF_FFFF);
        send_request(bal_pkg::K_SEARCH,  4'd15, 32'sh7FFF_FFFF);
        send_request(bal_pkg::K_SEARCH,  4'd0,  32'sd0);
        send_request(bal_pkg::K_SEARCH,  4'd0,  -32'sd1);
        send_request(bal_pkg::K_SEARCH,  4'd0,  32'sh8000_0000);
        send_request(bal_pkg::K_SEARCH,  4'd0,  32'sd12345);
        send_request(bal_pkg::K_MODIFY,  4'd4,  32'sh5555_5555);
        send_request(bal_pkg::K_MODIFY,  4'd5,  32'sd3);
        send_request(bal_pkg::K_MODIFY,  4'd15, 32'sd3);
        send_request(bal_pkg::K_REPLACE, 4'd0,  32'shAAAA_AAAA);
        send_request(bal_pkg::K_REPLACE, 4'd1,  32'sd0);
        send_request(bal_pkg::K_SEARCH,  4'd0,  32'sh5555_5555);
        send_request(bal_pkg::K_REPLACE, 4'd3,  32'sd0);
        send_request(bal_pkg::K_REPLACE, 4'd3,  32'sd1);
        send_request(bal_pkg::K_REPLACE, 4'd15, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_count < bal_pkg::CAPACITY)
            send_request(bal_pkg::K_APPEND, bal_pkg::POS_W'($urandom_range(0, 15)),
                         pick_value());
        repeat (3)
            send_request(bal_pkg::K_APPEND, bal_pkg::POS_W'($urandom_range(0, 15)),
                         $urandom);
        send_request(bal_pkg::K_SEARCH, 4'd0, shadow_entries[bal_pkg::CAPACITY-1]);
        send_request(bal_pkg::K_MODIFY, bal_pkg::POS_W'(bal_pkg::CAPACITY-1), $urandom);
        send_request(bal_pkg::K_REPLACE, bal_pkg::POS_W'(bal_pkg::CAPACITY-1),
                     32'sh7FFF_FFFF);
        send_request(bal_pkg::K_REPLACE, bal_pkg::POS_W'(bal_pkg::CAPACITY-1), 32'sd0);
        send_request(bal_pkg::K_APPEND, 4'd0, pick_value());
        send_request(bal_pkg::K_APPEND, 4'd0, pick_value());
        while (shadow_count > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(bal_pkg::K_SEARCH, pick_position(), pick_value());
            send_request(bal_pkg::K_REPLACE,
                         bal_pkg::POS_W'($urandom_range(0, shadow_count - 1)), 32'sd0);
        end
        send_request(bal_pkg::K_SEARCH, 4'd0, $urandom);
    endtask

    // weights in percent; what is left over goes to replace-or-remove
    task automatic test_random_mix(input int n, input int w_search, input int w_modify,
                                   input int w_append, input int remove_pct);
        int                                roll;
        bal_pkg::t_kind                    kind;
        logic signed [bal_pkg::DATA_W-1:0] val;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            val  = pick_value();
            if (roll < w_search)
                kind = bal_pkg::K_SEARCH;
            else if (roll < w_search + w_modify)
                kind = bal_pkg::K_MODIFY;
            else if (roll < w_search + w_modify + w_append)
                kind = bal_pkg::K_APPEND;
            else begin
                kind = bal_pkg::K_REPLACE;
                if ($urandom_range(0, 99) < remove_pct)
                    val = '0;
                else if (val == 0)
                    val = $urandom | 32'sd1;
            end
            send_request(kind, pick_position(), val);
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_mix(300, 25, 20, 30, 50);
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            sink_ready <= 1'b0;
        else
            sink_ready <= !take_gap();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            beats_seen++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected beat", bal_pkg::DATA_W'(rsp_ch.status), '0);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", bal_pkg::DATA_W'(rsp_ch.status),
                                    bal_pkg::DATA_W'(want.status));
                if (rsp_ch.found_index !== want.found_index)
                    report_mismatch("found_index", bal_pkg::DATA_W'(rsp_ch.found_index),
                                    bal_pkg::DATA_W'(want.found_index));
                if (rsp_ch.old_value !== want.old_value)
                    report_mismatch("old_value", rsp_ch.old_value, want.old_value);
                if (rsp_ch.new_value !== want.new_value)
                    report_mismatch("new_value", rsp_ch.new_value, want.new_value);
                if (rsp_ch.live_count !== want.live_count)
                    report_mismatch("live_count", bal_pkg::DATA_W'(rsp_ch.live_count),
                                    bal_pkg::DATA_W'(want.live_count));
            end
        end
    end

    // watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= bal_pkg::K_SEARCH;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_fill_to_capacity();
        test_random_mix(450, 20, 15, 45, 30);
        test_random_mix(400, 20, 15, 15, 70);
        test_fill_to_capacity();
        test_random_mix(600, 25, 20, 30, 50);
        test_back_to_back();

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_rsp.size() != 0)
            report_mismatch("beats left over", bal_pkg::DATA_W'(pending_rsp.size()), '0);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
